### design/p1crc_pkg.sv
// ----------------------------------------------------------------------------
// p1crc_pkg
// Shared types and constants of the P1 telegram CRC checker.
// ----------------------------------------------------------------------------
package p1crc_pkg;

    // reflected CRC-16 polynomial
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [7:0]  START_MARK = 8'h2F;   // '/'
    localparam logic [7:0]  END_MARK   = 8'h21;   // '!'

    // register indexes (paddr bit 2)
    localparam logic        REG_CRC_INIT    = 1'b0;
    localparam logic        REG_INCLUDE_END = 1'b1;

    localparam logic [15:0] CRC_INIT_RESET  = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_PASS     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_BAD_HEX  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // one result word, status in the lowest bits
    typedef struct packed {
        logic [11:0] telegram_length;
        logic [15:0] digits_crc;
        logic [15:0] computed_crc;
        status_t     status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

### design/p1crc_crc_byte.sv
// ----------------------------------------------------------------------------
// p1crc_crc_byte
// One byte of the reflected CRC-16 update, LSB first, no final xor.
// ----------------------------------------------------------------------------
module p1crc_crc_byte
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ p1crc_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

### design/p1crc_core.sv
// ----------------------------------------------------------------------------
// p1crc_core
// Telegram framing, running CRC, hex digit capture and the result register.
// ----------------------------------------------------------------------------
module p1crc_core
#(
    parameter int MAX_LEN = 2048
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         crc_init,
    input  logic                include_end_mark,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output p1crc_pkg::result_t  out_result
);

    localparam logic [11:0] LEN_LIMIT = 12'(MAX_LEN - 4);

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_BODY   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [15:0]        crc_reg, crc_next;
    logic [15:0]        text_reg, text_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [11:0]        len_reg, len_next;
    logic               herr_reg, herr_next;
    logic               out_valid_reg, out_valid_next;
    p1crc_pkg::result_t out_reg, out_next;

    logic        step;
    logic        is_start;
    logic [15:0] crc_src;
    logic [15:0] crc_upd;
    logic [3:0]  digit;
    logic        digit_bad;

    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'h10;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            r = {1'b0, 4'(ch - 8'h30)};
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            r = {1'b0, 4'(ch - 8'h37)};
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            r = {1'b0, 4'(ch - 8'h57)};
        end
        return r;
    endfunction

    assign in_ready   = !out_valid_reg || out_ready;
    assign step       = in_valid && in_ready;
    assign is_start   = (in_byte == p1crc_pkg::START_MARK);
    assign crc_src    = is_start ? crc_init : crc_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign {digit_bad, digit} = hex_value(in_byte);

    p1crc_crc_byte u_crc
    (
        .crc_in  (crc_src),
        .data    (in_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        logic [11:0] len_inc;
        logic [15:0] text_shift;
        logic        herr_acc;

        phase_next     = phase_reg;
        crc_next       = crc_reg;
        text_next      = text_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        herr_next      = herr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        len_inc    = len_reg + 12'd1;
        text_shift = {text_reg[11:0], digit};
        herr_acc   = herr_reg || digit_bad;

        if (step)
        begin
            if (is_start)
            begin
                crc_next   = crc_upd;
                len_next   = 12'd1;
                text_next  = '0;
                cnt_next   = '0;
                herr_next  = 1'b0;
                phase_next = PH_BODY;
            end
            else
            begin
                unique case (phase_reg)
                    PH_BODY:
                    begin
                        len_next = len_inc;
                        if (in_byte == p1crc_pkg::END_MARK)
                        begin
                            if (include_end_mark)
                            begin
                                crc_next = crc_upd;
                            end
                            text_next  = '0;
                            cnt_next   = '0;
                            herr_next  = 1'b0;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            crc_next = crc_upd;
                            // no room left for end mark and digits
                            if (len_inc >= LEN_LIMIT)
                            begin
                                out_valid_next           = 1'b1;
                                out_next.status          = p1crc_pkg::ST_OVERFLOW;
                                out_next.computed_crc    = crc_upd;
                                out_next.digits_crc      = '0;
                                out_next.telegram_length = len_inc;
                                phase_next               = PH_HUNT;
                            end
                        end
                    end
                    PH_DIGITS:
                    begin
                        text_next = text_shift;
                        herr_next = herr_acc;
                        if (cnt_reg == 2'd3)
                        begin
                            out_valid_next = 1'b1;
                            if (herr_acc)
                            begin
                                out_next.status = p1crc_pkg::ST_BAD_HEX;
                            end
                            else if (crc_reg == text_shift)
                            begin
                                out_next.status = p1crc_pkg::ST_PASS;
                            end
                            else
                            begin
                                out_next.status = p1crc_pkg::ST_MISMATCH;
                            end
                            out_next.computed_crc    = crc_reg;
                            out_next.digits_crc      = text_shift;
                            out_next.telegram_length = len_reg;
                            cnt_next                 = '0;
                            phase_next               = PH_HUNT;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            crc_reg       <= '0;
            text_reg      <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            herr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            text_reg      <= text_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            herr_reg      <= herr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word carries no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTH
    a_pass_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == p1crc_pkg::ST_PASS
        |-> out_reg.computed_crc == out_reg.digits_crc)
        else $error("pass reported with differing crc values");

    a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == p1crc_pkg::ST_OVERFLOW
        |-> out_reg.digits_crc == 16'h0000 && out_reg.telegram_length == LEN_LIMIT)
        else $error("overflow word with wrong fields");

    a_digits_only: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> phase_reg == PH_DIGITS)
        else $error("digit count running outside digit phase");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_start |=> phase_reg == PH_BODY && len_reg == 12'd1)
        else $error("start mark did not restart the telegram");
`endif

endmodule

### design/p1_telegram_crc_checker.sv
// ----------------------------------------------------------------------------
// p1_telegram_crc_checker
// CRC-16 check of P1 smart meter telegrams, one received character a word.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one received character per word in s_tdata. '/' starts (or
//   restarts) a telegram, the body runs up to '!', then four hex digits.
//   m_axis: one word per telegram: pass, crc mismatch, bad hex text or
//   overflow when the telegram, '/' included, reaches MAX_LEN-4 bytes. A
//   dropped telegram (restarted by '/') gives no word.
//   apb: register 0 crc_init at 0x0, register 1 include_end_mark at 0x4.
//   Write only while no character is in flight.
// timing
//   one character per cycle sustained while m_tready keeps up. The last
//   crc digit is registered in the input register, then the result word
//   in the output register, which drives m_tvalid.
//   The byte-wide CRC update and state step form the single stage.
// reset and stalls
//   rst_n clears the framing state (hunting for '/'), empties both
//   registers and sets crc_init to 0xFFFF, include_end_mark to 0.
//   While m_tready is low and a word waits, one more character is held
//   in the input register and s_tready then drops.
// ----------------------------------------------------------------------------
module p1_telegram_crc_checker
#(
    parameter int MAX_LEN = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // rx_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], computed_crc[17:2], digits_crc[33:18],
    // telegram_length[45:34], zero fill[47:46]
    output logic [47:0] m_tdata
);

    localparam int FILL_W = 48 - p1crc_pkg::RESULT_W;

    logic [15:0]        crc_init_reg;
    logic               incl_end_reg;
    logic               cfg_write;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               core_ready;
    p1crc_pkg::result_t core_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_init_reg <= p1crc_pkg::CRC_INIT_RESET;
            incl_end_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                p1crc_pkg::REG_CRC_INIT:    crc_init_reg <= pwdata[15:0];
                p1crc_pkg::REG_INCLUDE_END: incl_end_reg <= pwdata[0];
                default:                    crc_init_reg <= crc_init_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            p1crc_pkg::REG_CRC_INIT:    prdata = {16'h0000, crc_init_reg};
            p1crc_pkg::REG_INCLUDE_END: prdata = {31'h0, incl_end_reg};
            default:                    prdata = '0;
        endcase
    end

    // input register, refilled in the same cycle it drains
    assign s_tready = !in_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    p1crc_core
    #(
        .MAX_LEN (MAX_LEN)
    )
    u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .crc_init         (crc_init_reg),
        .include_end_mark (incl_end_reg),
        .in_valid         (in_valid_reg),
        .in_byte          (in_byte_reg),
        .in_ready         (core_ready),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_result       (core_result)
    );

    assign m_tdata = {{FILL_W{1'b0}}, core_result};

endmodule
